@@ rtl/brle_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// brle_pkg: shared types and constants of the byte run-length decoder
// Field widths, tag layout, phase encoding, error and action codes.
// ----------------------------------------------------------------------------
package brle_pkg;

  // length accumulator width and number of tag bits in the first control byte
  localparam int unsigned LEN_WIDTH = 32;
  localparam int unsigned TAG_BITS  = 2;

  // widths of the item fields
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned RUNLEN_W = 32;
  localparam int unsigned ERR_W    = 3;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned PADDR_W  = 3;

  // register index within the configuration space (paddr bit 2)
  localparam logic REG_OUTPUT_TOTAL = 1'b0;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CTRL = 2'd0,
    ACT_CODE = 2'd1,
    ACT_END  = 2'd2,
    ACT_RSVD = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    RT_ZERO    = 2'd0,
    RT_FF      = 2'd1,
    RT_FILL    = 2'd2,
    RT_LITERAL = 2'd3
  } run_type_e;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_CTRL_MORE  = 3'd1,
    PH_NEED_VALUE = 3'd2,
    PH_LITERAL    = 3'd3,
    PH_ENDED      = 3'd4,
    PH_FAULT      = 3'd5
  } phase_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE       = 3'd0,
    ERR_OVERFLOW   = 3'd1,
    ERR_TOO_LONG   = 3'd2,
    ERR_WRONG_KIND = 3'd3,
    ERR_INCOMPLETE = 3'd4
  } err_e;

endpackage
`default_nettype wire

@@ rtl/brle_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// brle_in_if: input channel of the run-length decoder
// Carries one control byte, code byte or end marker per transfer.
// ----------------------------------------------------------------------------
interface brle_in_if;
  logic                             valid;
  logic                             ready;
  logic [brle_pkg::ACTION_W-1:0]    action;
  logic [brle_pkg::BYTE_W-1:0]      in_byte;

  modport source (output valid, output action, output in_byte, input ready);
  modport sink   (input valid, input action, input in_byte, output ready);
endinterface
`default_nettype wire

@@ rtl/brle_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// brle_out_if: result channel of the run-length decoder
// Carries one run descriptor and the decoder status per transfer.
// ----------------------------------------------------------------------------
interface brle_out_if;
  logic                             valid;
  logic                             ready;
  logic                             emit;
  logic [brle_pkg::BYTE_W-1:0]      run_value;
  logic [brle_pkg::RUNLEN_W-1:0]    run_length;
  logic                             need_code;
  logic                             done_res;
  logic [brle_pkg::ERR_W-1:0]       err_code;

  modport source (output valid, output emit, output run_value, output run_length,
                  output need_code, output done_res, output err_code, input ready);
  modport sink   (input valid, input emit, input run_value, input run_length,
                  input need_code, input done_res, input err_code, output ready);
endinterface
`default_nettype wire

@@ rtl/byte_rle_run_decoder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// byte_rle_run_decoder: byte run-length stream decoder
// Turns control and code bytes into run descriptors and stream status.
// ----------------------------------------------------------------------------
// The decoder takes one byte item per clock and answers each with exactly one
// result: a run descriptor when a run is complete plus the current status
// (which stream is needed next, done, sticky error). An input transfer is
// held in the input register, then its result in the result register; the
// sustained rate is one item per cycle while results are taken, as the
// phase, length accumulator and remaining-output counter update per item.
// Input stalls only while a finished result waits to be taken and the input
// register is full. Program output_total over the APB port (byte address 0)
// before the stream; a write also reloads the remaining-output counter.
module byte_rle_run_decoder (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              psel_i,
  input  wire                              penable_i,
  input  wire                              pwrite_i,
  input  wire  [brle_pkg::PADDR_W-1:0]     paddr_i,
  input  wire  [brle_pkg::CFG_W-1:0]       pwdata_i,
  output logic [brle_pkg::CFG_W-1:0]       prdata_o,
  output logic                             pready_o,
  brle_in_if.sink                          in_i,
  brle_out_if.source                       out_o
);

  localparam int unsigned ACC_W     = brle_pkg::LEN_WIDTH;
  localparam int unsigned CMP_W     = (ACC_W > brle_pkg::RUNLEN_W) ? ACC_W
                                                                   : brle_pkg::RUNLEN_W;
  localparam int unsigned TAG_SHIFT = brle_pkg::BYTE_W - brle_pkg::TAG_BITS;
  localparam int unsigned VBITS     = 7 - brle_pkg::TAG_BITS;
  localparam int unsigned OVF_SHIFT = ACC_W - 7;
  localparam logic [brle_pkg::BYTE_W-1:0] VMASK =
    brle_pkg::BYTE_W'((1 << VBITS) - 1);

  // configuration
  logic [brle_pkg::CFG_W-1:0] output_total_q;
  logic                       cfg_wr;

  // input register
  logic                           s1_valid_q;
  brle_pkg::action_e              s1_action_q;
  logic [brle_pkg::BYTE_W-1:0]    s1_byte_q;

  // decoder state
  brle_pkg::phase_e               phase_q, phase_d;
  brle_pkg::run_type_e            rtype_q, rtype_d;
  logic [ACC_W-1:0]               acc_q, acc_d;
  logic [brle_pkg::RUNLEN_W-1:0]  lit_left_q, lit_left_d;
  logic [brle_pkg::RUNLEN_W-1:0]  out_left_q, out_left_d;
  brle_pkg::err_e                 err_q, err_d;

  // run produced by this item
  logic                           run_emit;
  logic [brle_pkg::BYTE_W-1:0]    run_val;
  logic [brle_pkg::RUNLEN_W-1:0]  run_len;

  // result register
  logic                           out_valid_q;
  logic                           emit_q, emit_d;
  logic [brle_pkg::BYTE_W-1:0]    value_q, value_d;
  logic [brle_pkg::RUNLEN_W-1:0]  length_q, length_d;
  logic                           need_q, need_d;
  logic                           done_q, done_d;
  logic [brle_pkg::ERR_W-1:0]     errc_q;

  logic advance;

  assign advance  = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;

  // APB register
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i &&
                    (paddr_i[2] == brle_pkg::REG_OUTPUT_TOTAL);

  always_comb begin
    if (paddr_i[2] == brle_pkg::REG_OUTPUT_TOTAL) begin
      prdata_o = output_total_q;
    end else begin
      prdata_o = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      output_total_q <= '0;
    end else if (cfg_wr) begin
      output_total_q <= pwdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_action_q <= brle_pkg::action_e'(in_i.action);
      s1_byte_q   <= in_i.in_byte;
    end
  end

  // next state of the decoder for the item in the input register
  always_comb begin
    logic [ACC_W-1:0]               acc_new;
    logic [CMP_W-1:0]               acc_cmp;
    logic [CMP_W-1:0]               left_cmp;
    logic [brle_pkg::RUNLEN_W-1:0]  len;
    logic                           more;
    logic                           group;
    brle_pkg::run_type_e            rt_new;

    phase_d    = phase_q;
    rtype_d    = rtype_q;
    acc_d      = acc_q;
    lit_left_d = lit_left_q;
    out_left_d = out_left_q;
    err_d      = err_q;
    run_emit   = 1'b0;
    run_val    = '0;
    run_len    = '0;
    acc_new    = '0;
    more       = 1'b0;
    group      = 1'b0;
    rt_new     = rtype_q;

    if (phase_q != brle_pkg::PH_FAULT) begin
      case (s1_action_q)
        brle_pkg::ACT_END: begin
          if (phase_q == brle_pkg::PH_ENDED) begin
            phase_d = brle_pkg::PH_ENDED;
          end else if (phase_q == brle_pkg::PH_IDLE && out_left_q == '0) begin
            phase_d = brle_pkg::PH_ENDED;
          end else begin
            err_d   = brle_pkg::ERR_INCOMPLETE;
            phase_d = brle_pkg::PH_FAULT;
          end
        end
        brle_pkg::ACT_CTRL: begin
          if (phase_q == brle_pkg::PH_IDLE) begin
            rt_new  = brle_pkg::run_type_e'(2'(s1_byte_q >> TAG_SHIFT));
            rtype_d = rt_new;
            acc_new = ACC_W'(s1_byte_q & VMASK);
            more    = s1_byte_q[VBITS];
            group   = 1'b1;
          end else if (phase_q == brle_pkg::PH_CTRL_MORE) begin
            acc_new = (acc_q << 7) | ACC_W'(s1_byte_q[6:0]);
            more    = s1_byte_q[7];
            group   = 1'b1;
          end else begin
            err_d   = brle_pkg::ERR_WRONG_KIND;
            phase_d = brle_pkg::PH_FAULT;
          end
        end
        brle_pkg::ACT_CODE: begin
          if (phase_q == brle_pkg::PH_NEED_VALUE) begin
            run_emit   = 1'b1;
            run_val    = s1_byte_q;
            run_len    = lit_left_q;
            lit_left_d = '0;
            phase_d    = brle_pkg::PH_IDLE;
          end else if (phase_q == brle_pkg::PH_LITERAL) begin
            run_emit   = 1'b1;
            run_val    = s1_byte_q;
            run_len    = brle_pkg::RUNLEN_W'(1);
            lit_left_d = lit_left_q - brle_pkg::RUNLEN_W'(1);
            if (lit_left_q == brle_pkg::RUNLEN_W'(1)) begin
              phase_d = brle_pkg::PH_IDLE;
            end
          end else begin
            err_d   = brle_pkg::ERR_WRONG_KIND;
            phase_d = brle_pkg::PH_FAULT;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end

    // close a varint group: continue, overflow, reject a too-long length, or finish it
    acc_cmp  = CMP_W'(acc_new);
    left_cmp = CMP_W'(out_left_q);
    len      = brle_pkg::RUNLEN_W'(acc_cmp) + brle_pkg::RUNLEN_W'(1);
    if (group) begin
      if (more) begin
        if ((acc_new >> OVF_SHIFT) != '0) begin
          err_d   = brle_pkg::ERR_OVERFLOW;
          phase_d = brle_pkg::PH_FAULT;
        end else begin
          acc_d   = acc_new;
          phase_d = brle_pkg::PH_CTRL_MORE;
        end
      end else if (acc_cmp >= left_cmp) begin
        err_d   = brle_pkg::ERR_TOO_LONG;
        phase_d = brle_pkg::PH_FAULT;
      end else begin
        out_left_d = out_left_q - len;
        acc_d      = '0;
        case (rt_new)
          brle_pkg::RT_ZERO: begin
            run_emit = 1'b1;
            run_val  = '0;
            run_len  = len;
            phase_d  = brle_pkg::PH_IDLE;
          end
          brle_pkg::RT_FF: begin
            run_emit = 1'b1;
            run_val  = '1;
            run_len  = len;
            phase_d  = brle_pkg::PH_IDLE;
          end
          brle_pkg::RT_FILL: begin
            lit_left_d = len;
            phase_d    = brle_pkg::PH_NEED_VALUE;
          end
          default: begin
            lit_left_d = len;
            phase_d    = brle_pkg::PH_LITERAL;
          end
        endcase
      end
    end
  end

  // result fields from the next state
  always_comb begin
    if (phase_d == brle_pkg::PH_FAULT) begin
      emit_d   = 1'b0;
      value_d  = '0;
      length_d = '0;
    end else begin
      emit_d   = run_emit;
      value_d  = run_val;
      length_d = run_len;
    end
    need_d = (phase_d == brle_pkg::PH_NEED_VALUE) || (phase_d == brle_pkg::PH_LITERAL);
    done_d = ((phase_d == brle_pkg::PH_IDLE) || (phase_d == brle_pkg::PH_ENDED)) &&
             (out_left_d == '0) && (err_d == brle_pkg::ERR_NONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= brle_pkg::PH_IDLE;
      rtype_q    <= brle_pkg::RT_ZERO;
      acc_q      <= '0;
      lit_left_q <= '0;
      out_left_q <= '0;
      err_q      <= brle_pkg::ERR_NONE;
    end else begin
      if (advance) begin
        phase_q    <= phase_d;
        rtype_q    <= rtype_d;
        acc_q      <= acc_d;
        lit_left_q <= lit_left_d;
        err_q      <= err_d;
      end
      // a register write reloads the remaining count, keeping the position
      if (cfg_wr) begin
        out_left_q <= pwdata_i;
      end else if (advance) begin
        out_left_q <= out_left_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      emit_q   <= emit_d;
      value_q  <= value_d;
      length_q <= length_d;
      need_q   <= need_d;
      done_q   <= done_d;
      errc_q   <= err_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.emit       = emit_q;
  assign out_o.run_value  = value_q;
  assign out_o.run_length = length_q;
  assign out_o.need_code  = need_q;
  assign out_o.done_res   = done_q;
  assign out_o.err_code   = errc_q;

`ifndef ASSERT_OFF
  // a run is never reported together with an error
  a_emit_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && emit_q) |-> (errc_q == brle_pkg::ERR_NONE))
    else $error("run emitted with error set");

  // errors stick until reset
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != brle_pkg::ERR_NONE) |=> (err_q == $past(err_q)))
    else $error("error code changed after being set");

  // done implies no pending code byte and no error
  a_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && done_q) |-> (!need_q && errc_q == brle_pkg::ERR_NONE))
    else $error("done reported with pending work or error");

  // input stalls only behind a held result
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (s1_valid_q && out_valid_q && !out_o.ready))
    else $error("input stalled without a held result");
`endif

endmodule
`default_nettype wire

@@ dv/byte_rle_run_decoder_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_rle_run_decoder_checker: result predictor and scoreboard
// Watches the configuration port and both channels. Keeps its own copy of the
// decoder state, predicts the result of every input transfer and compares
// each result transfer with the oldest prediction. It also checks read-back
// of the output total register.
// ----------------------------------------------------------------------------
module byte_rle_run_decoder_checker
  import brle_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 psel_i,
  input  wire                 penable_i,
  input  wire                 pwrite_i,
  input  wire  [PADDR_W-1:0]  paddr_i,
  input  wire  [CFG_W-1:0]    pwdata_i,
  input  wire  [CFG_W-1:0]    prdata_i,
  input  wire                 pready_i,
  brle_in_if                  in_mon,
  brle_out_if                 out_mon,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  localparam int unsigned VBITS = 7 - TAG_BITS;

  typedef struct packed {
    logic                emit;
    logic [BYTE_W-1:0]   value;
    logic [RUNLEN_W-1:0] length;
    logic                need_code;
    logic                done;
    logic [ERR_W-1:0]    err;
  } run_status_t;

  // decoder state as seen from outside
  phase_e         dec_phase;
  run_type_e      dec_type;
  logic [63:0]    len_accum;
  logic [31:0]    lit_left;
  logic [31:0]    out_left;
  logic [31:0]    total_reg;
  err_e           dec_err;

  run_status_t    expected_runs[$];
  int unsigned    mismatch_count;

  function automatic void raise_error(err_e code);
    dec_err   = code;
    dec_phase = PH_FAULT;
  endfunction

  function automatic void close_length(inout run_status_t r);
    logic [31:0] len;
    if (len_accum >= {32'd0, out_left}) begin
      raise_error(ERR_TOO_LONG);
      return;
    end
    len       = len_accum[31:0] + 32'd1;
    out_left  = out_left - len;
    len_accum = '0;
    case (dec_type)
      RT_ZERO, RT_FF: begin
        r.emit    = 1'b1;
        r.value   = (dec_type == RT_FF) ? 8'hFF : 8'h00;
        r.length  = len;
        dec_phase = PH_IDLE;
      end
      RT_FILL: begin
        lit_left  = len;
        dec_phase = PH_NEED_VALUE;
      end
      default: begin
        lit_left  = len;
        dec_phase = PH_LITERAL;
      end
    endcase
  endfunction

  function automatic void group_done(logic more, inout run_status_t r);
    if (more) begin
      if ((len_accum >> (LEN_WIDTH - 7)) != 0) raise_error(ERR_OVERFLOW);
      else dec_phase = PH_CTRL_MORE;
    end else begin
      close_length(r);
    end
  endfunction

  function automatic run_status_t decode_byte(logic [ACTION_W-1:0] act, logic [7:0] b);
    run_status_t r;
    r = '0;
    if (dec_phase != PH_FAULT && act != ACT_RSVD) begin
      case (act)
        ACT_END: begin
          if (dec_phase == PH_ENDED) begin
            // repeated end: nothing changes
          end else if (dec_phase == PH_IDLE && out_left == 0) begin
            dec_phase = PH_ENDED;
          end else begin
            raise_error(ERR_INCOMPLETE);
          end
        end
        ACT_CTRL: begin
          if (dec_phase == PH_IDLE) begin
            dec_type  = run_type_e'(2'((b >> (8 - TAG_BITS)) & 8'h03));
            len_accum = 64'(b & 8'((1 << VBITS) - 1));
            group_done(b[VBITS], r);
          end else if (dec_phase == PH_CTRL_MORE) begin
            len_accum = (len_accum << 7) | 64'(b[6:0]);
            group_done(b[7], r);
          end else begin
            raise_error(ERR_WRONG_KIND);
          end
        end
        default: begin
          if (dec_phase == PH_NEED_VALUE) begin
            r.emit    = 1'b1;
            r.value   = b;
            r.length  = lit_left;
            lit_left  = '0;
            dec_phase = PH_IDLE;
          end else if (dec_phase == PH_LITERAL) begin
            r.emit   = 1'b1;
            r.value  = b;
            r.length = 32'd1;
            lit_left = lit_left - 32'd1;
            if (lit_left == 0) dec_phase = PH_IDLE;
          end else begin
            raise_error(ERR_WRONG_KIND);
          end
        end
      endcase
    end
    if (dec_phase == PH_FAULT) begin
      r.emit   = 1'b0;
      r.value  = '0;
      r.length = '0;
    end
    r.need_code = (dec_phase == PH_NEED_VALUE || dec_phase == PH_LITERAL);
    r.done      = (dec_phase == PH_IDLE || dec_phase == PH_ENDED) && out_left == 0 &&
                  dec_err == ERR_NONE;
    r.err       = dec_err;
    return r;
  endfunction

  function automatic string fmt_status(run_status_t s);
    return $sformatf("emit=%0b val=%02h len=%08h need=%0b done=%0b err=%0d",
                     s.emit, s.value, s.length, s.need_code, s.done, s.err);
  endfunction

  function automatic void log_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t ns: %s", $time, what);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    run_status_t got;
    run_status_t want;
    if (!rst_ni) begin
      dec_phase      = PH_IDLE;
      dec_type       = RT_ZERO;
      len_accum      = '0;
      lit_left       = '0;
      out_left       = '0;
      total_reg      = '0;
      dec_err        = ERR_NONE;
      mismatch_count = 0;
      expected_runs.delete();
      fail_count_o  <= 0;
      pending_o     <= 0;
    end else begin
      if (psel_i && penable_i && pready_i && paddr_i[2] == REG_OUTPUT_TOTAL) begin
        if (pwrite_i) begin
          // a write also reloads the remaining output count
          total_reg = pwdata_i;
          out_left  = pwdata_i;
        end else if (prdata_i !== total_reg) begin
          log_mismatch($sformatf("output_total read-back: exp %08h got %08h",
                                 total_reg, prdata_i));
        end
      end
      // compare before predicting so a same-edge input is never taken as the match
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.emit, out_mon.run_value, out_mon.run_length, out_mon.need_code,
               out_mon.done_res, out_mon.err_code};
        if (expected_runs.size() == 0) begin
          log_mismatch({"unexpected result: ", fmt_status(got)});
        end else begin
          want = expected_runs.pop_front();
          if (got !== want)
            log_mismatch({"result mismatch: exp ", fmt_status(want),
                          " got ", fmt_status(got)});
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_runs.push_back(decode_byte(in_mon.action, in_mon.in_byte));
      fail_count_o <= mismatch_count;
      pending_o    <= expected_runs.size();
    end
  end

endmodule

@@ dv/byte_rle_run_decoder_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_rle_run_decoder_tb: stimulus and verdict for the run-length decoder
// Programs the output total, feeds directed then random well-formed run
// streams with random gaps and result stalls, ends with one randomly chosen
// stream termination or fault, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module byte_rle_run_decoder_tb;
  import brle_pkg::*;

  localparam int unsigned VBITS     = 7 - TAG_BITS;
  localparam int unsigned ITEM_GOAL = 2000;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [CFG_W-1:0]   pwdata;
  logic [CFG_W-1:0]   prdata;
  logic               pready;
  int unsigned        fail_count;
  int unsigned        pending;

  brle_in_if  in_ch ();
  brle_out_if out_ch ();

  // stimulus bookkeeping
  logic [31:0]  budget;
  int unsigned  items_sent;
  bit           offering;
  bit           idle_send;
  bit           idle_recv;
  bit           hold_off_req;

  byte_rle_run_decoder uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .in_i      (in_ch),
    .out_o     (out_ch)
  );

  byte_rle_run_decoder_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .prdata_i     (prdata),
    .pready_i     (pready),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // result side: per-result stall, with one long hold-off on request
  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        stall        = 400;
        hold_off_req = 1'b0;
      end else begin
        stall = idle_recv ? $urandom_range(13, 0) : 0;
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  // one APB transfer; leaves psel high so a second transfer can follow directly
  task automatic apb_xfer(input logic wr, input logic [CFG_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {REG_OUTPUT_TOTAL, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic set_total(input logic [31:0] value);
    apb_xfer(1'b1, value);
    apb_xfer(1'b0, '0);
    psel    <= 1'b0;
    penable <= 1'b0;
    budget   = value;
  endtask

  task automatic send_item(input action_e act, input logic [7:0] b);
    int unsigned gap;
    gap = idle_send ? $urandom_range(13, 0) : 0;
    if (gap != 0) begin
      if (offering) in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.action  <= act;
    in_ch.in_byte <= b;
    offering = 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic stop_offer();
    if (offering) in_ch.valid <= 1'b0;
    offering = 1'b0;
  endtask

  task automatic drain();
    stop_offer();
    do @(posedge clk_i); while (pending != 0);
  endtask

  // encode one run as a tagged varint, sometimes with leading zero groups, then its code bytes
  task automatic send_run(input run_type_e rt, input logic [31:0] len);
    logic [63:0] v;
    int unsigned groups;
    logic [7:0]  first;
    v      = 64'(len - 32'd1);
    groups = 0;
    while ((v >> (VBITS + 7 * groups)) != 0) groups++;
    if ($urandom_range(9, 0) == 0) groups += $urandom_range(2, 1);
    first = 8'((64'(rt) << (8 - TAG_BITS)) | (64'(groups != 0) << VBITS) |
               ((v >> (7 * groups)) & ((64'd1 << VBITS) - 1)));
    send_item(ACT_CTRL, first);
    for (int g = int'(groups) - 1; g >= 0; g--)
      send_item(ACT_CTRL, {g != 0, 7'(v >> (7 * g))});
    if (rt == RT_FILL) send_item(ACT_CODE, 8'($urandom));
    else if (rt == RT_LITERAL) repeat (len) send_item(ACT_CODE, 8'($urandom));
    budget = budget - len;
  endtask

  task automatic send_random_run();
    run_type_e   rt;
    logic [31:0] len;
    int unsigned pick;
    rt   = run_type_e'(2'($urandom_range(3, 0)));
    pick = $urandom_range(99, 0);
    if (rt == RT_LITERAL) len = (pick < 90) ? $urandom_range(8, 1) : $urandom_range(40, 1);
    else if (pick < 70) len = $urandom_range(64, 1);
    else if (pick < 95) len = $urandom_range(65535, 1);
    else len = $urandom_range(32'h0FFF_FFFF, 1);
    if (len > budget) len = budget;
    send_run(rt, len);
  endtask

  task automatic random_phase(input int unsigned n);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < n && budget != 0) begin
      // sprinkle reserved items, which the decoder must ignore
      if ($urandom_range(19, 0) == 0) send_item(ACT_RSVD, 8'($urandom));
      send_random_run();
    end
  endtask

  task automatic choose_idling();
    logic [1:0] m;
    m         = 2'($urandom_range(3, 0));
    idle_send = m[0];
    idle_recv = m[1];
  endtask

  // close the stream: one good end or one fault, chosen by the seed
  task automatic finish_stream();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(7, 0);
    if (pick != 0 && pick != 2) set_total(32'hFFFF_FFFF);
    case (pick)
      0: begin
        n = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(40, 1);
        set_total(n);
        while (budget != 0) send_random_run();
        send_item(ACT_END, 8'($urandom));
        send_item(ACT_END, 8'($urandom));
        // any byte after a good end is the wrong kind
        send_item(action_e'(1'($urandom)), 8'($urandom));
      end
      1: begin
        // varint overflow on the fourth control byte
        send_item(ACT_CTRL, 8'($urandom_range(3, 0) << 6) | 8'h3F);
        repeat (3) send_item(ACT_CTRL, 8'hFF);
      end
      2: begin
        n = $urandom_range(20, 0);
        set_total(n);
        send_run(run_type_e'(2'($urandom_range(3, 0))), n + 1 + $urandom_range(5, 0));
      end
      3: begin
        // code byte where a control byte belongs, at a run start or mid-varint
        if ($urandom_range(1, 0) != 0) send_item(ACT_CTRL, 8'h20);
        send_item(ACT_CODE, 8'($urandom));
      end
      4: begin
        send_item(ACT_CTRL, ($urandom_range(1, 0) != 0) ? 8'hC0 : 8'h80);
        send_item(ACT_CTRL, 8'($urandom));
      end
      5: begin
        send_item(ACT_CTRL, 8'($urandom_range(3, 0) << 6) | 8'h20);
        send_item(ACT_END, 8'($urandom));
      end
      6: begin
        send_item(ACT_CTRL, ($urandom_range(1, 0) != 0) ? 8'hC3 : 8'h80);
        send_item(ACT_END, 8'($urandom));
      end
      default: send_item(ACT_END, 8'($urandom));
    endcase
    // everything after the outcome must leave the status untouched
    repeat (12) send_item(action_e'(2'($urandom_range(3, 0))), 8'($urandom));
  endtask

  initial begin
    int unsigned phase_no;
    int unsigned pick;
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.action  <= ACT_CTRL;
    in_ch.in_byte <= '0;
    items_sent    = 0;
    offering      = 1'b0;
    hold_off_req  = 1'b0;
    idle_send     = 1'b1;
    idle_recv     = 1'b1;
    budget        = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every run type, byte extremes and non-minimal varints
    set_total(32'hFFFF_FFFF);
    send_item(ACT_RSVD, 8'hFF);
    send_item(ACT_CTRL, 8'h00);
    send_item(ACT_CTRL, 8'h40);
    send_item(ACT_CTRL, 8'h80);
    send_item(ACT_CODE, 8'hFF);
    send_item(ACT_CTRL, 8'hC1);
    send_item(ACT_CODE, 8'h00);
    send_item(ACT_CODE, 8'hA5);
    send_item(ACT_CTRL, 8'h7F);
    send_item(ACT_CTRL, 8'h7F);
    send_item(ACT_CTRL, 8'h20);
    send_item(ACT_CTRL, 8'h80);
    send_item(ACT_CTRL, 8'h00);
    drain();
    // a single run of the full 32-bit length empties the output count
    set_total(32'hFFFF_FFFF);
    send_run(RT_FILL, 32'hFFFF_FFFF);
    send_item(ACT_RSVD, 8'h00);
    drain();
    set_total(32'd0);
    send_item(ACT_RSVD, 8'h5A);
    drain();

    phase_no = 0;
    while (items_sent < ITEM_GOAL) begin
      choose_idling();
      pick = $urandom_range(2, 0);
      // the hold-off phase needs a long stream to back up the input
      if (phase_no == 1) pick = 0;
      if (pick == 0) set_total(32'hFFFF_FFFF);
      else if (pick == 1) set_total($urandom);
      else set_total($urandom_range(5000, 1));
      if (phase_no == 1) begin
        // keep offering while results are held back so the input stalls
        idle_send    = 1'b0;
        hold_off_req = 1'b1;
      end
      random_phase(250);
      drain();
      phase_no++;
    end

    choose_idling();
    finish_stream();
    drain();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ byte_rle_run_decoder.f @@
rtl/brle_pkg.sv
rtl/brle_in_if.sv
rtl/brle_out_if.sv
rtl/byte_rle_run_decoder.sv
dv/byte_rle_run_decoder_checker.sv
dv/byte_rle_run_decoder_tb.sv
